// ===== hdl/swdp_pkg.sv =====
// Shared types and constants for the store-wait dependence predictor.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps

package swdp_pkg;

    localparam int LOAD_ENTRIES_DEF  = 16;
    localparam int STORE_ENTRIES_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 64;
    localparam int SEQ_W    = 64;
    localparam int PERIOD_W = 20;

    localparam logic [PERIOD_W-1:0] WIPE_PERIOD_RESET = 20'd250000;

    typedef enum logic [CMD_W-1:0] {
        CMD_VIOLATION   = 3'd0,
        CMD_INSERT_LOAD = 3'd1,
        CMD_INSERT_STORE = 3'd2,
        CMD_CHECK       = 3'd3,
        CMD_ISSUED      = 3'd4,
        CMD_SQUASH      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VSCAN,
        ST_SSCAN,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } state_t;

endpackage

// ===== hdl/swdp_if.sv =====
// Request and result channel interfaces for the store-wait dependence predictor.
// Depends on swdp_pkg for field widths.
`timescale 1ns / 1ps

interface swdp_req_if;
    logic                           valid;
    logic                           ready;
    logic [swdp_pkg::CMD_W-1:0]     command;
    logic [swdp_pkg::ADDR_W-1:0]    pc;
    logic [swdp_pkg::SEQ_W-1:0]     seq_num;
    logic                           store_flag;

    modport source (output valid, command, pc, seq_num, store_flag, input ready);
    modport sink   (input valid, command, pc, seq_num, store_flag, output ready);
endinterface

interface swdp_res_if;
    logic                           valid;
    logic                           ready;
    logic [swdp_pkg::SEQ_W-1:0]     store_seq;
    logic                           found;
    logic                           last;

    modport source (output valid, store_seq, found, last, input ready);
    modport sink   (input valid, store_seq, found, last, output ready);
endinterface

// ===== hdl/store_wait_dependence_predictor_unit.sv =====
// Store-wait memory dependence predictor, top level.
// Depends on swdp_pkg and the channel interfaces in swdp_if.sv.
`timescale 1ns / 1ps
//
//  channel | dir | handshake        | contents
//  --------+-----+------------------+----------------------------------------
//  req     | in  | valid / ready    | command, pc, seq_num, store_flag
//  rsp     | out | valid / ready    | store_seq, found, last
//  cfg     | in  | cfg_we (no wait) | wipe period in cfg_wdata
//
//  Request handling: insert-load, ignored codes and issued on a load return
//  straight to idle; a check on a store goes straight to its result. Violation
//  walks the violator table; insert-store, issued on a store and squash walk the
//  pending-store memory. Any other check walks the violator table; a known
//  violator with k older stores then takes k + 1 walks over the pending-store
//  memory, and every result passes through an emit state that loads the output
//  register. Result stalls hold the emit states. Requests are taken only in idle.
//  Reset clears every valid bit, the counter and the pointer at once; no sweep.
//  Output is registered: a new request is taken while the last result waits.

module store_wait_dependence_predictor_unit #(
    parameter int LOAD_ENTRIES  = swdp_pkg::LOAD_ENTRIES_DEF,
    parameter int STORE_ENTRIES = swdp_pkg::STORE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    swdp_req_if.sink                          req,
    swdp_res_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [swdp_pkg::PERIOD_W-1:0]     cfg_wdata
);

    localparam int LW   = $clog2(LOAD_ENTRIES);
    localparam int SW   = $clog2(STORE_ENTRIES);
    localparam int MAXE = (LOAD_ENTRIES > STORE_ENTRIES) ? LOAD_ENTRIES : STORE_ENTRIES;
    localparam int CW   = $clog2(MAXE + 1);
    localparam int PW   = swdp_pkg::PERIOD_W;
    localparam int DW   = swdp_pkg::SEQ_W;

    // Sequencer and request state
    swdp_pkg::state_t state_reg, state_next;
    swdp_pkg::cmd_t   cmd_reg, cmd_next;
    logic [swdp_pkg::ADDR_W-1:0] pc_reg, pc_next;
    logic [DW-1:0]               seq_reg, seq_next;

    logic [PW-1:0] wipe_period_reg, wipe_period_next;
    logic [PW-1:0] op_cnt_reg, op_cnt_next;

    // Table valid bits and replacement pointer
    logic [LOAD_ENTRIES-1:0]  vvalid_reg, vvalid_next;
    logic [STORE_ENTRIES-1:0] svalid_reg, svalid_next;
    logic [LW-1:0]            vnext_reg, vnext_next;

    // Scan engine: issue counter, registered read pipe
    logic [CW-1:0] issue_reg, issue_next;
    logic          pvld_reg, pvld_next;
    logic [CW-1:0] pidx_reg, pidx_next;

    // Scan results
    logic          hit_reg, hit_next;
    logic          free_found_reg, free_found_next;
    logic [CW-1:0] free_idx_reg, free_idx_next;
    logic          got_reg, got_next;
    logic [DW-1:0] best_reg, best_next;
    logic          have_held_reg, have_held_next;
    logic [DW-1:0] held_reg, held_next;

    // Output register
    logic          out_vld_reg, out_vld_next;
    logic [DW-1:0] out_seq_reg, out_seq_next;
    logic          out_found_reg, out_found_next;
    logic          out_last_reg, out_last_next;

    // Memories
    logic [swdp_pkg::ADDR_W-1:0] vpc_mem [LOAD_ENTRIES];
    logic [DW-1:0]               sseq_mem [STORE_ENTRIES];
    logic [swdp_pkg::ADDR_W-1:0] vrd_reg;
    logic [DW-1:0]               srd_reg;
    logic                        vwe, swe;
    logic [LW-1:0]               vwaddr;
    logic [SW-1:0]               swaddr;

    // Compare logic outputs
    logic v_ent, s_ent, pc_eq, s_eq, s_lt, s_gt_held, s_lt_best;
    logic last_l, last_s, out_free, scan_n_more;
    logic [PW:0] cnt_inc;

    assign v_ent     = vvalid_reg[pidx_reg[LW-1:0]];
    assign s_ent     = svalid_reg[pidx_reg[SW-1:0]];
    assign pc_eq     = (vrd_reg == pc_reg);
    assign s_eq      = (srd_reg == seq_reg);
    assign s_lt      = (srd_reg < seq_reg);
    assign s_gt_held = (srd_reg > held_reg);
    assign s_lt_best = (srd_reg < best_reg);
    assign last_l    = pvld_reg && (pidx_reg == CW'(LOAD_ENTRIES - 1));
    assign last_s    = pvld_reg && (pidx_reg == CW'(STORE_ENTRIES - 1));
    assign out_free  = !out_vld_reg || rsp.ready;
    assign cnt_inc   = {1'b0, op_cnt_reg} + {{PW{1'b0}}, 1'b1};
    assign scan_n_more = (state_reg == swdp_pkg::ST_VSCAN)
                       ? (issue_reg < CW'(LOAD_ENTRIES))
                       : (issue_reg < CW'(STORE_ENTRIES));

    assign req.ready     = (state_reg == swdp_pkg::ST_IDLE);
    assign rsp.valid     = out_vld_reg;
    assign rsp.store_seq = out_seq_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.last      = out_last_reg;

    // Memory ports: read at the issue counter, write at end of a scan
    always_ff @(posedge clk)
    begin
        vrd_reg <= vpc_mem[issue_reg[LW-1:0]];
        if (vwe)
        begin
            vpc_mem[vwaddr] <= pc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        srd_reg <= sseq_mem[issue_reg[SW-1:0]];
        if (swe)
        begin
            sseq_mem[swaddr] <= seq_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swdp_pkg::ST_IDLE;
            cmd_reg          <= swdp_pkg::CMD_VIOLATION;
            wipe_period_reg  <= swdp_pkg::WIPE_PERIOD_RESET;
            op_cnt_reg       <= '0;
            vvalid_reg       <= '0;
            svalid_reg       <= '0;
            vnext_reg        <= '0;
            issue_reg        <= '0;
            pvld_reg         <= 1'b0;
            pidx_reg         <= '0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            got_reg          <= 1'b0;
            have_held_reg    <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            wipe_period_reg  <= wipe_period_next;
            op_cnt_reg       <= op_cnt_next;
            vvalid_reg       <= vvalid_next;
            svalid_reg       <= svalid_next;
            vnext_reg        <= vnext_next;
            issue_reg        <= issue_next;
            pvld_reg         <= pvld_next;
            pidx_reg         <= pidx_next;
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            got_reg          <= got_next;
            have_held_reg    <= have_held_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pc_reg        <= pc_next;
        seq_reg       <= seq_next;
        best_reg      <= best_next;
        held_reg      <= held_next;
        out_seq_reg   <= out_seq_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        pc_next           = pc_reg;
        seq_next          = seq_reg;
        wipe_period_next  = wipe_period_reg;
        op_cnt_next       = op_cnt_reg;
        vvalid_next       = vvalid_reg;
        svalid_next       = svalid_reg;
        vnext_next        = vnext_reg;
        issue_next        = issue_reg;
        pvld_next         = 1'b0;
        pidx_next         = pidx_reg;
        hit_next          = hit_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        got_next          = got_reg;
        best_next         = best_reg;
        have_held_next    = have_held_reg;
        held_next         = held_reg;
        out_vld_next      = out_vld_reg && !rsp.ready;
        out_seq_next      = out_seq_reg;
        out_found_next    = out_found_reg;
        out_last_next     = out_last_reg;
        vwe               = 1'b0;
        swe               = 1'b0;
        vwaddr            = vnext_reg;
        swaddr            = free_idx_reg[SW-1:0];

        if (cfg_we)
        begin
            wipe_period_next = cfg_wdata;
        end

        // Advance the read pipe through the table being walked
        if ((state_reg == swdp_pkg::ST_VSCAN || state_reg == swdp_pkg::ST_SSCAN)
            && scan_n_more)
        begin
            issue_next = issue_reg + CW'(1);
            pvld_next  = 1'b1;
            pidx_next  = issue_reg;
        end

        unique case (state_reg)
            swdp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = swdp_pkg::cmd_t'(req.command);
                    pc_next         = req.pc;
                    seq_next        = req.seq_num;
                    issue_next      = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    got_next        = 1'b0;
                    have_held_next  = 1'b0;

                    // Count memory ops; wipe both tables once past the period
                    if (req.command == swdp_pkg::CMD_INSERT_LOAD
                        || req.command == swdp_pkg::CMD_INSERT_STORE)
                    begin
                        if (cnt_inc > {1'b0, wipe_period_reg})
                        begin
                            op_cnt_next = '0;
                            vvalid_next = '0;
                            svalid_next = '0;
                        end
                        else
                        begin
                            op_cnt_next = cnt_inc[PW-1:0];
                        end
                    end

                    unique case (req.command)
                        swdp_pkg::CMD_VIOLATION:    state_next = swdp_pkg::ST_VSCAN;
                        swdp_pkg::CMD_INSERT_LOAD:  state_next = swdp_pkg::ST_IDLE;
                        swdp_pkg::CMD_INSERT_STORE: state_next = swdp_pkg::ST_SSCAN;
                        swdp_pkg::CMD_CHECK:
                            state_next = req.store_flag ? swdp_pkg::ST_EMIT_LAST
                                                        : swdp_pkg::ST_VSCAN;
                        swdp_pkg::CMD_ISSUED:
                            state_next = req.store_flag ? swdp_pkg::ST_SSCAN
                                                        : swdp_pkg::ST_IDLE;
                        swdp_pkg::CMD_SQUASH:       state_next = swdp_pkg::ST_SSCAN;
                        default:                    state_next = swdp_pkg::ST_IDLE;
                    endcase
                end
            end

            swdp_pkg::ST_VSCAN:
            begin
                if (pvld_reg)
                begin
                    if (v_ent && pc_eq)
                    begin
                        hit_next = 1'b1;
                    end
                    if (!v_ent && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end
                if (last_l)
                begin
                    if (cmd_reg == swdp_pkg::CMD_VIOLATION)
                    begin
                        // Lowest free slot, else replace round-robin
                        if (!hit_next)
                        begin
                            vwe = 1'b1;
                            if (free_found_next)
                            begin
                                vwaddr = free_idx_next[LW-1:0];
                            end
                            else
                            begin
                                vwaddr     = vnext_reg;
                                vnext_next = (vnext_reg == LW'(LOAD_ENTRIES - 1))
                                           ? '0 : vnext_reg + LW'(1);
                            end
                            vvalid_next[vwaddr] = 1'b1;
                        end
                        state_next = swdp_pkg::ST_IDLE;
                    end
                    else if (hit_next)
                    begin
                        issue_next = '0;
                        pvld_next  = 1'b0;
                        got_next   = 1'b0;
                        state_next = swdp_pkg::ST_SSCAN;
                    end
                    else
                    begin
                        state_next = swdp_pkg::ST_EMIT_LAST;
                    end
                end
            end

            swdp_pkg::ST_SSCAN:
            begin
                if (pvld_reg)
                begin
                    priority case (cmd_reg)
                        swdp_pkg::CMD_INSERT_STORE:
                        begin
                            if (s_ent && s_eq)
                            begin
                                hit_next = 1'b1;
                            end
                            if (!s_ent && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = pidx_reg;
                            end
                        end
                        swdp_pkg::CMD_ISSUED:
                        begin
                            if (s_ent && s_eq)
                            begin
                                svalid_next[pidx_reg[SW-1:0]] = 1'b0;
                            end
                        end
                        swdp_pkg::CMD_SQUASH:
                        begin
                            if (s_ent && !s_lt && !s_eq)
                            begin
                                svalid_next[pidx_reg[SW-1:0]] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Check pass: smallest store below the load and above
                            // the last one found
                            if (s_ent && s_lt && (!have_held_reg || s_gt_held)
                                && (!got_reg || s_lt_best))
                            begin
                                got_next  = 1'b1;
                                best_next = srd_reg;
                            end
                        end
                    endcase
                end
                if (last_s)
                begin
                    priority case (cmd_reg)
                        swdp_pkg::CMD_INSERT_STORE:
                        begin
                            if (!hit_next && free_found_next)
                            begin
                                swe    = 1'b1;
                                swaddr = free_idx_next[SW-1:0];
                                svalid_next[swaddr] = 1'b1;
                            end
                            state_next = swdp_pkg::ST_IDLE;
                        end
                        swdp_pkg::CMD_CHECK:
                        begin
                            if (!got_next)
                            begin
                                state_next = swdp_pkg::ST_EMIT_LAST;
                            end
                            else if (have_held_reg)
                            begin
                                state_next = swdp_pkg::ST_EMIT_MID;
                            end
                            else
                            begin
                                // First store found: hold it and walk again
                                held_next      = best_next;
                                have_held_next = 1'b1;
                                issue_next     = '0;
                                pvld_next      = 1'b0;
                                got_next       = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = swdp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            swdp_pkg::ST_EMIT_MID:
            begin
                // Send the held store, keep the newer one, start the next pass
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_seq_next   = held_reg;
                    out_found_next = 1'b1;
                    out_last_next  = 1'b0;
                    held_next      = best_reg;
                    issue_next     = '0;
                    got_next       = 1'b0;
                    state_next     = swdp_pkg::ST_SSCAN;
                end
            end

            swdp_pkg::ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_seq_next   = have_held_reg ? held_reg : '0;
                    out_found_next = have_held_reg;
                    out_last_next  = 1'b1;
                    state_next     = swdp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = swdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/swdp_chk.sv =====
// Port-level checker for the store-wait dependence predictor, with its bind.
// Depends on swdp_pkg and store_wait_dependence_predictor_unit.
`timescale 1ns / 1ps

module swdp_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic [swdp_pkg::CMD_W-1:0]     req_command,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [swdp_pkg::SEQ_W-1:0]     rsp_store_seq,
    input logic                           rsp_found,
    input logic                           rsp_last
);

    // A stalled result holds its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_store_seq)
            && $stable(rsp_found) && $stable(rsp_last))
        else $error("result changed while stalled");

    // A not-found result always closes its check
    a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_last)
        else $error("not-found result without last");

    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_store_seq == '0)
        else $error("not-found result carries a sequence number");

    // A check request always holds off the next request: the block leaves idle on taking it
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_command == swdp_pkg::CMD_CHECK |=> !req_ready)
        else $error("check request did not hold off the next request");

endmodule

bind store_wait_dependence_predictor_unit swdp_chk u_swdp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_command   (req.command),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_store_seq (rsp.store_seq),
    .rsp_found     (rsp.found),
    .rsp_last      (rsp.last)
);
